[src/bidirectional_scan_line_reverser_assert.svh]
// Assertion macros for the scan line reverser.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef BIDIRECTIONAL_SCAN_LINE_REVERSER_ASSERT_SVH
`define BIDIRECTIONAL_SCAN_LINE_REVERSER_ASSERT_SVH
`ifndef SYNTHESIS
`define BSLR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bslr assertion failed");
`define BSLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bslr assertion failed");
`else
`define BSLR_ASSERT_SAME(lbl, ante, cons)
`define BSLR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/bslr_pkg.sv]
// Shared constants for the scan line reverser.
// No dependencies.
`default_nettype none
package bslr_pkg;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_W        = 8;
  localparam int LINE_WIDTH_W   = 11;
  localparam int FRAME_HEIGHT_W = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd256;
  localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd256;
endpackage
`default_nettype wire

[src/bslr_in_if.sv]
// Input pixel channel: valid/ready plus op and pixel.
// Depends on bslr_pkg.
`default_nettype none
interface bslr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [bslr_pkg::PIXEL_W-1:0] pixel_in;
  modport source (output valid, op, pixel_in, input ready);
  modport sink   (input valid, op, pixel_in, output ready);
endinterface
`default_nettype wire

[src/bslr_out_if.sv]
// Result channel: valid/ready plus corrected pixel and end-of-line flag.
// Depends on bslr_pkg.
`default_nettype none
interface bslr_out_if;
  logic                         valid;
  logic                         ready;
  logic [bslr_pkg::PIXEL_W-1:0] pixel_out;
  logic                         last_of_line;
  modport source (output valid, pixel_out, last_of_line, input ready);
  modport sink   (input valid, pixel_out, last_of_line, output ready);
endinterface
`default_nettype wire

[src/bslr_cfg_if.sv]
// Configuration write channel: valid/ready plus register index and data.
// Depends on bslr_pkg.
`default_nettype none
interface bslr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bslr_pkg::CFG_IDX_W-1:0]  index;
  logic [bslr_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/bslr_line_ram.sv]
// Ping-pong line store: one write port, one registered read port.
// No package dependencies.
`default_nettype none
module bslr_line_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);
  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

[src/bidirectional_scan_line_reverser.sv]
// Scan line reverser top: one pixel beat per cycle unless out_ch stalls; registered output.
// The line store takes one write and one read per cycle, which sets the one-beat rate.
// Output lags input by one line; drain beats empty the held line after the stream ends.
// Reset (rst_n, synchronous, active low) clears control state and restores register
// defaults; line store contents stay undefined until written, with no clearing pass.
`default_nettype none
`include "bidirectional_scan_line_reverser_assert.svh"
module bidirectional_scan_line_reverser #(
  parameter int MAX_WIDTH = bslr_pkg::MAX_WIDTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst_n,
  bslr_in_if.sink     in_ch,
  bslr_out_if.source  out_ch,
  bslr_cfg_if.sink    cfg_ch
);
  localparam int COL_W  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ADDR_W = COL_W + 1;
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (WID_W > bslr_pkg::LINE_WIDTH_W) ? WID_W : bslr_pkg::LINE_WIDTH_W;
  localparam int FH_W   = bslr_pkg::FRAME_HEIGHT_W;
  localparam int PIX_W  = bslr_pkg::PIXEL_W;

  // configuration
  logic [bslr_pkg::LINE_WIDTH_W-1:0] line_width_r;
  logic [FH_W-1:0]                   frame_height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= bslr_pkg::LINE_WIDTH_RST;
      frame_height_r <= bslr_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bslr_pkg::REG_LINE_WIDTH: begin
          line_width_r <= cfg_ch.data[bslr_pkg::LINE_WIDTH_W-1:0];
        end
        bslr_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= cfg_ch.data[FH_W-1:0];
        end
      endcase
    end
  end

  // line state
  logic [COL_W-1:0] column_r, column_nxt;
  logic [FH_W-1:0]  lif_r, lif_nxt;
  logic             wbank_r, wbank_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic             held_rev_r, held_rev_nxt;
  logic             draining_r, draining_nxt;

  // pipeline
  logic             s1_vld_r, s1_last_r;
  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_pix_r;
  logic [PIX_W-1:0] rd_data;
  logic             s1_adv, acc;

  // per-beat decode
  logic [CMP_W-1:0] lw_ext;
  logic [COL_W-1:0] wm1, col, pos;
  logic             last;
  logic [FH_W-1:0]  h_eff;
  logic [FH_W:0]    lif_inc;
  logic             is_pix, drain_ok, emit, wr_en;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;

  always_comb begin
    lw_ext = CMP_W'(line_width_r);
    priority if (lw_ext < CMP_W'(2)) begin
      wm1 = COL_W'(1);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(lw_ext - CMP_W'(1));
    end
  end

  assign col     = (column_r > wm1) ? wm1 : column_r;
  assign last    = (col == wm1);
  assign pos     = held_rev_r ? (wm1 - col) : col;
  assign h_eff   = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
  assign lif_inc = {1'b0, lif_r} + (FH_W+1)'(1);

  assign is_pix   = (in_ch.op == bslr_pkg::OP_PIXEL);
  assign drain_ok = (draining_r || column_r == '0) && held_valid_r;
  assign emit     = is_pix ? (!draining_r && held_valid_r) : drain_ok;
  assign wr_en    = acc && is_pix && !draining_r;

  always_comb begin
    column_nxt     = column_r;
    lif_nxt        = lif_r;
    wbank_nxt      = wbank_r;
    held_valid_nxt = held_valid_r;
    held_rev_nxt   = held_rev_r;
    draining_nxt   = draining_r;
    if (acc) begin
      if (is_pix) begin
        if (!draining_r) begin
          if (last) begin
            column_nxt     = '0;
            held_valid_nxt = 1'b1;
            held_rev_nxt   = lif_r[0];
            wbank_nxt      = !wbank_r;
            lif_nxt        = (lif_inc >= {1'b0, h_eff}) ? '0 : lif_inc[FH_W-1:0];
          end else begin
            column_nxt = col + COL_W'(1);
          end
        end
      end else if (drain_ok) begin
        if (last) begin
          column_nxt     = '0;
          held_valid_nxt = 1'b0;
          draining_nxt   = 1'b0;
          lif_nxt        = '0;
        end else begin
          draining_nxt = 1'b1;
          column_nxt   = col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      lif_r        <= '0;
      wbank_r      <= 1'b0;
      held_valid_r <= 1'b0;
      held_rev_r   <= 1'b0;
      draining_r   <= 1'b0;
    end else begin
      column_r     <= column_nxt;
      lif_r        <= lif_nxt;
      wbank_r      <= wbank_nxt;
      held_valid_r <= held_valid_nxt;
      held_rev_r   <= held_rev_nxt;
      draining_r   <= draining_nxt;
    end
  end

  bslr_line_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({wbank_r, col}),
    .wr_data (in_ch.pixel_in),
    .rd_en   (acc && emit),
    .rd_addr ({!wbank_r, pos}),
    .rd_data (rd_data)
  );

  // read stage, then output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (acc) begin
      s1_vld_r <= emit;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pix_r  <= rd_data;
      out_last_r <= s1_last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_out    = out_pix_r;
  assign out_ch.last_of_line = out_last_r;

  `BSLR_ASSERT_SAME(a_drain_needs_held, draining_r, held_valid_r)
  `BSLR_ASSERT_NEXT(a_s1_hold, s1_vld_r && !s1_adv, s1_vld_r && $stable(rd_data))
  `BSLR_ASSERT_NEXT(a_drain_end, acc && !is_pix && drain_ok && last,
                    !held_valid_r && !draining_r && column_r == '0 && lif_r == '0)
endmodule
`default_nettype wire

[dv/bslr_tb_pkg.sv]
// Line order tracker for the scan line reverser bench: mirrors the ping-pong store,
// the line and frame counters and the drain state, and checks each output beat.
// Depends on bslr_pkg.
`timescale 1ns / 100ps
package bslr_tb_pkg;
  import bslr_pkg::*;

  localparam int STORE_DEPTH = 2 * MAX_WIDTH_DEF;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               end_of_line;
  } out_beat_t;

  class line_reorder_tracker;
    logic [PIXEL_W-1:0]        store_pixels [STORE_DEPTH];
    bit                        store_written [STORE_DEPTH];
    int unsigned               column;
    int unsigned               line_in_frame;
    bit                        write_bank;
    bit                        held_valid;
    bit                        held_reversed;
    bit                        draining;
    logic [LINE_WIDTH_W-1:0]   line_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    out_beat_t                 corrected_pixels[$];
    int unsigned               beats_taken;
    int unsigned               results_seen;
    int unsigned               fail_count;

    function new();
      column        = 0;
      line_in_frame = 0;
      write_bank    = 1'b0;
      held_valid    = 1'b0;
      held_reversed = 1'b0;
      draining      = 1'b0;
      line_width    = LINE_WIDTH_RST;
      frame_height  = FRAME_HEIGHT_RST;
      beats_taken   = 0;
      results_seen  = 0;
      fail_count    = 0;
    endfunction

    function int unsigned clamp_width(logic [LINE_WIDTH_W-1:0] raw);
      int unsigned w;
      w = raw;
      if (w < 2) return 2;
      if (w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return w;
    endfunction

    function int unsigned effective_width();
      return clamp_width(line_width);
    endfunction

    function int unsigned effective_height();
      return (frame_height == 0) ? 1 : frame_height;
    endfunction

    function bit mid_line();
      return (column != 0) && !draining;
    endfunction

    function bit line_held();
      return held_valid;
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_LINE_WIDTH) begin
        line_width = data[LINE_WIDTH_W-1:0];
      end else begin
        frame_height = data[FRAME_HEIGHT_W-1:0];
      end
    endfunction

    function logic [PIXEL_W-1:0] held_pixel(int unsigned col, int unsigned w);
      int unsigned addr;
      addr = (write_bank ? 0 : MAX_WIDTH_DEF) + (held_reversed ? (w - 1 - col) : col);
      if (!store_written[addr]) begin
        note_failure($sformatf("bench read unwritten line store entry %0d", addr));
      end
      return store_pixels[addr];
    endfunction

    function void accept_beat(logic op, logic [PIXEL_W-1:0] pix);
      int unsigned w;
      int unsigned col;
      int unsigned addr;
      bit          last;
      out_beat_t   beat;
      w    = effective_width();
      col  = (column < w) ? column : (w - 1);
      last = (col == w - 1);
      if (op == OP_PIXEL) begin
        if (draining) return;
        beats_taken++;
        if (held_valid) begin
          beat.pixel       = held_pixel(col, w);
          beat.end_of_line = last;
          corrected_pixels.push_back(beat);
        end
        addr = (write_bank ? MAX_WIDTH_DEF : 0) + col;
        store_pixels[addr]  = pix;
        store_written[addr] = 1'b1;
        if (last) begin
          column        = 0;
          held_valid    = 1'b1;
          held_reversed = (line_in_frame % 2) != 0;
          write_bank    = !write_bank;
          line_in_frame++;
          if (line_in_frame >= effective_height()) line_in_frame = 0;
        end else begin
          column = col + 1;
        end
        return;
      end
      // drain beat: ignored mid-line, no-op with nothing held
      if (!draining && column != 0) return;
      if (!held_valid) return;
      beats_taken++;
      draining         = 1'b1;
      beat.pixel       = held_pixel(col, w);
      beat.end_of_line = last;
      corrected_pixels.push_back(beat);
      if (last) begin
        column        = 0;
        held_valid    = 1'b0;
        draining      = 1'b0;
        line_in_frame = 0;
      end else begin
        column = col + 1;
      end
    endfunction

    function void check_beat(logic [PIXEL_W-1:0] pix, logic last);
      out_beat_t want;
      results_seen++;
      if (corrected_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result %0d: pixel %02h last %0b",
                               results_seen, pix, last));
        return;
      end
      want = corrected_pixels.pop_front();
      if (pix !== want.pixel || last !== want.end_of_line) begin
        note_failure($sformatf("result %0d: expected pixel %02h last %0b, got pixel %02h last %0b",
                               results_seen, want.pixel, want.end_of_line, pix, last));
      end
    endfunction

    function void close_out();
      if (corrected_pixels.size() != 0) begin
        note_failure($sformatf("%0d expected results never arrived", corrected_pixels.size()));
      end
    endfunction
  endclass
endpackage

[dv/tb_bidirectional_scan_line_reverser.sv]
// Top-level bench for the scan line reverser: drives pixel, drain and register beats
// with random idling and a long output hold, and checks every output beat in order.
// Depends on bslr_pkg, the three channel interfaces and bslr_tb_pkg.
`timescale 1ns / 100ps
module tb_bidirectional_scan_line_reverser;
  import bslr_pkg::*;
  import bslr_tb_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int HOLD_CYCLES   = 200;
  localparam int RANDOM_BEATS  = 450;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bslr_in_if  in_ch();
  bslr_out_if out_ch();
  bslr_cfg_if cfg_ch();

  bidirectional_scan_line_reverser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  line_reorder_tracker reorder = new();

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 71;
  bit          hold_request  = 1'b0;
  int unsigned quiet_cycles  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) reorder.check_beat(out_ch.pixel_out, out_ch.last_of_line);
      if (in_ch.valid && in_ch.ready) reorder.accept_beat(in_ch.op, in_ch.pixel_in);
      if (cfg_ch.valid && cfg_ch.ready) reorder.set_register(cfg_ch.index, cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("bidirectional_scan_line_reverser: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic logic [PIXEL_W-1:0] any_pixel();
    return PIXEL_W'($urandom);
  endfunction

  task automatic send_beat(input logic op, input logic [PIXEL_W-1:0] pix);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.op       <= op;
    in_ch.pixel_in <= pix;
    in_ch.valid    <= 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (reorder.corrected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic flush_stream();
    while (reorder.mid_line()) send_beat(OP_PIXEL, any_pixel());
    while (reorder.line_held()) send_beat(OP_DRAIN, any_pixel());
    wait_idle();
  endtask

  // a wider line must never read a held line past the entries it wrote
  task automatic set_width(input logic [CFG_DATA_W-1:0] data);
    if (reorder.clamp_width(data[LINE_WIDTH_W-1:0]) > reorder.effective_width() &&
        reorder.line_held()) begin
      flush_stream();
    end else begin
      wait_idle();
    end
    write_cfg(REG_LINE_WIDTH, data);
  endtask

  task automatic set_height(input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    write_cfg(REG_FRAME_HEIGHT, data);
  endtask

  task automatic send_line();
    do begin
      if (reorder.mid_line() && $urandom_range(0, 29) == 0) send_beat(OP_DRAIN, any_pixel());
      send_beat(OP_PIXEL, any_pixel());
    end while (reorder.mid_line());
  endtask

  task automatic drain_line();
    send_beat(OP_DRAIN, any_pixel());
    while (reorder.draining) begin
      if ($urandom_range(0, 9) == 0) send_beat(OP_PIXEL, any_pixel());
      send_beat(OP_DRAIN, any_pixel());
    end
    if ($urandom_range(0, 3) == 0) send_beat(OP_DRAIN, any_pixel());
  endtask

  task automatic reconfigure();
    int unsigned pick;
    int unsigned w;
    logic [CFG_DATA_W-1:0] data;
    pick = $urandom_range(0, 19);
    if (pick < 13) w = $urandom_range(2, 12);
    else if (pick < 18) w = $urandom_range(13, 40);
    else if (pick < 19) w = $urandom_range(0, 1);
    else w = $urandom_range(64, 160);
    data = CFG_DATA_W'($urandom);
    data[LINE_WIDTH_W-1:0] = w[LINE_WIDTH_W-1:0];
    set_width(data);
    case ($urandom_range(0, 5))
      0: data = 16'd0;
      1: data = 16'd1;
      2: data = 16'd2;
      3: data = CFG_DATA_W'($urandom_range(3, 9));
      4: data = 16'hFFFF;
      default: data = CFG_DATA_W'($urandom);
    endcase
    set_height(data);
  endtask

  task automatic run_episode();
    int unsigned cut;
    logic [CFG_DATA_W-1:0] data;
    while (reorder.draining) send_beat(OP_DRAIN, any_pixel());
    if ($urandom_range(0, 3) == 0) reconfigure();
    repeat ($urandom_range(1, 4)) send_line();
    case ($urandom_range(0, 3))
      0: ;
      1: drain_line();
      2: begin
        // cut a line short, shrink or re-time the frame, then finish the line
        cut = $urandom_range(1, reorder.effective_width() - 1);
        repeat (cut) send_beat(OP_PIXEL, any_pixel());
        if ($urandom_range(0, 2) != 0) begin
          data = CFG_DATA_W'($urandom);
          data[LINE_WIDTH_W-1:0] = LINE_WIDTH_W'($urandom_range(2, reorder.effective_width()));
          set_width(data);
        end else begin
          set_height(CFG_DATA_W'($urandom_range(0, 5)));
        end
        send_line();
      end
      default: begin
        repeat ($urandom_range(1, 4)) send_beat(logic'($urandom_range(0, 1)), any_pixel());
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned goal;
    int unsigned left;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_PIXEL;
    in_ch.pixel_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_LINE_WIDTH;
    cfg_ch.data    = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // width 0 acts as 2, height 0 acts as 1
    set_height(16'd0);
    set_width(16'd0);
    send_beat(OP_DRAIN, 8'h5A);
    send_beat(OP_PIXEL, 8'h00);
    send_beat(OP_DRAIN, 8'hFF);
    send_beat(OP_PIXEL, 8'hFF);
    send_beat(OP_PIXEL, 8'h55);
    send_beat(OP_PIXEL, 8'hAA);
    set_height(16'd2);
    set_width(16'd1);
    send_beat(OP_PIXEL, 8'h01);
    send_beat(OP_PIXEL, 8'h02);
    send_beat(OP_PIXEL, 8'h03);
    send_beat(OP_PIXEL, 8'h04);
    send_beat(OP_PIXEL, 8'h05);
    send_beat(OP_PIXEL, 8'h06);
    send_beat(OP_DRAIN, 8'h00);
    send_beat(OP_PIXEL, 8'h77);
    send_beat(OP_DRAIN, 8'h00);
    send_beat(OP_DRAIN, 8'h00);
    // shrink the width under a half-written line
    set_height(16'd3);
    set_width(16'd4);
    send_beat(OP_PIXEL, 8'h10);
    send_beat(OP_PIXEL, 8'h20);
    send_beat(OP_PIXEL, 8'h30);
    send_beat(OP_PIXEL, 8'h40);
    send_beat(OP_PIXEL, 8'h80);
    send_beat(OP_PIXEL, 8'h90);
    set_width(16'd2);
    send_beat(OP_PIXEL, 8'hA0);
    flush_stream();

    // 0xFFFF clamps to full width; shrinking then ends the line early
    set_width(16'hFFFF);
    repeat (5) send_beat(OP_PIXEL, any_pixel());
    set_width(16'd4);
    send_beat(OP_PIXEL, any_pixel());
    flush_stream();

    // output held off while input keeps coming
    set_width(16'd8);
    hold_request = 1'b1;
    repeat (48) send_beat(OP_PIXEL, any_pixel());
    flush_stream();

    goal = reorder.beats_taken + RANDOM_BEATS;
    while (reorder.beats_taken < goal) begin
      left = goal - reorder.beats_taken;
      if (left < RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (left < 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 16;
      end
      run_episode();
    end
    flush_stream();
    repeat (END_CYCLES) @(negedge clk);
    reorder.close_out();
    if (reorder.fail_count == 0) begin
      $display("bidirectional_scan_line_reverser: match");
    end else begin
      $display("bidirectional_scan_line_reverser: mismatch");
    end
    $finish;
  end
endmodule
